FILE: src/nts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_pkg
// Shared types and constants for the note tone sequencer.
// ----------------------------------------------------------------------------
package nts_pkg;

    localparam int unsigned REST_CAP_DEFAULT = 500000;
    localparam int unsigned LIMIT_W          = 26;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 26'd7000000;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_LOAD  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [23:0] rest_delay;
        logic [15:0] tone_period;
        logic [23:0] tone_duration;
        logic        final_note;
    } t_in;

    typedef struct packed {
        logic pin_level;
        logic note_ready;
        logic stopped;
        logic finished;
        logic rejected;
    } t_out;

endpackage
`default_nettype wire

FILE: src/nts_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_core
// Player state registers and the next-state logic for one command.
// ----------------------------------------------------------------------------
module nts_core #(
    parameter int unsigned REST_CAP = nts_pkg::REST_CAP_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_step,
    input  wire nts_pkg::t_in                i_item,
    input  wire logic                        i_cfg_we,
    input  wire logic [nts_pkg::LIMIT_W-1:0] i_cfg_data,
    output nts_pkg::t_out                    o_result
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_READY, PH_REST, PH_HIGH, PH_LOW, PH_STOPPED, PH_FINISHED
    } t_phase;

    localparam logic [18:0] CAP = 19'(REST_CAP);

    t_phase r_phase, n_phase;
    logic [18:0] r_rest, n_rest;
    logic [14:0] r_half, n_half;
    logic [15:0] r_period, n_period;
    logic [23:0] r_duration, n_duration;
    logic [24:0] r_elapsed, n_elapsed;
    logic [26:0] r_total, n_total;
    logic        r_final, n_final;
    logic        r_pin, n_pin;
    logic [nts_pkg::LIMIT_W-1:0] r_limit;

    logic        rejected;
    logic        do_tone;
    logic [24:0] tn_elapsed;
    logic [24:0] end_elapsed;
    logic [26:0] tn_total;
    logic [26:0] end_total;
    logic [15:0] tn_period;
    logic [23:0] tn_duration;
    logic        tn_final;
    logic [18:0] rest_capped;

    always_comb begin
        n_phase    = r_phase;
        n_rest     = r_rest;
        n_half     = r_half;
        n_period   = r_period;
        n_duration = r_duration;
        n_elapsed  = r_elapsed;
        n_total    = r_total;
        n_final    = r_final;
        n_pin      = r_pin;
        rejected   = 1'b0;
        do_tone    = 1'b0;
        tn_elapsed = r_elapsed;
        tn_total   = r_total;
        tn_period  = r_period;
        tn_duration = r_duration;
        tn_final   = r_final;
        rest_capped = (i_item.rest_delay > 24'(CAP)) ? CAP : i_item.rest_delay[18:0];
        end_elapsed = '0;
        end_total   = '0;

        case (i_item.cmd)
            nts_pkg::CMD_START: begin
                n_total   = '0;
                n_pin     = 1'b0;
                n_rest    = '0;
                n_half    = '0;
                n_elapsed = '0;
                n_phase   = PH_READY;
            end
            nts_pkg::CMD_LOAD: begin
                if (r_phase != PH_READY) begin
                    rejected = 1'b1;
                end else begin
                    n_rest     = rest_capped;
                    n_total    = r_total + 27'(rest_capped);
                    n_period   = i_item.tone_period;
                    n_duration = i_item.tone_duration;
                    n_final    = i_item.final_note;
                    n_elapsed  = '0;
                    n_pin      = 1'b0;
                    if (rest_capped != '0) begin
                        n_phase = PH_REST;
                    end else begin
                        // No rest: the tone starts within this same command.
                        do_tone     = 1'b1;
                        tn_elapsed  = '0;
                        tn_total    = r_total;
                        tn_period   = i_item.tone_period;
                        tn_duration = i_item.tone_duration;
                        tn_final    = i_item.final_note;
                    end
                end
            end
            nts_pkg::CMD_TICK: begin
                case (r_phase)
                    PH_REST: begin
                        n_rest = r_rest - 19'd1;
                        if (r_rest == 19'd1) begin
                            do_tone = 1'b1;
                        end
                    end
                    PH_HIGH: begin
                        n_half = r_half - 15'd1;
                        if (r_half == 15'd1) begin
                            n_pin   = 1'b0;
                            n_half  = r_period[15:1];
                            n_phase = PH_LOW;
                        end
                    end
                    PH_LOW: begin
                        n_half = r_half - 15'd1;
                        if (r_half == 15'd1) begin
                            do_tone    = 1'b1;
                            tn_elapsed = r_elapsed + 25'(r_period);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase

        if (do_tone) begin
            if (tn_elapsed < 25'(tn_duration) && tn_period[15:1] != '0) begin
                n_pin     = 1'b1;
                n_half    = tn_period[15:1];
                n_phase   = PH_HIGH;
                n_elapsed = tn_elapsed;
            end else begin
                // A period of one plays in no time but counts the whole duration.
                end_elapsed = (tn_elapsed < 25'(tn_duration) && tn_period == 16'd1) ?
                              25'(tn_duration) : tn_elapsed;
                end_total = tn_total + 27'(end_elapsed);
                n_elapsed = end_elapsed;
                n_total   = end_total;
                n_pin     = 1'b0;
                if (end_total > 27'(r_limit)) begin
                    n_phase = PH_STOPPED;
                end else if (tn_final) begin
                    n_phase = PH_FINISHED;
                end else begin
                    n_phase = PH_READY;
                end
            end
        end

        o_result.pin_level  = n_pin;
        o_result.note_ready = (n_phase == PH_READY);
        o_result.stopped    = (n_phase == PH_STOPPED);
        o_result.finished   = (n_phase == PH_STOPPED) || (n_phase == PH_FINISHED);
        o_result.rejected   = rejected;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_rest     <= '0;
            r_half     <= '0;
            r_period   <= '0;
            r_duration <= '0;
            r_elapsed  <= '0;
            r_total    <= '0;
            r_final    <= 1'b0;
            r_pin      <= 1'b0;
            r_limit    <= nts_pkg::LIMIT_RESET;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_step) begin
                r_phase    <= n_phase;
                r_rest     <= n_rest;
                r_half     <= n_half;
                r_period   <= n_period;
                r_duration <= n_duration;
                r_elapsed  <= n_elapsed;
                r_total    <= n_total;
                r_final    <= n_final;
                r_pin      <= n_pin;
            end
        end
    end

endmodule
`default_nettype wire

FILE: src/note_tone_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// note_tone_sequencer
// Buzzer note player: one command in, one status result out.
// ----------------------------------------------------------------------------
// Every accepted command (start, load note or one-microsecond tick) yields one
// result showing the pin level and player status after that command. A command
// is taken every cycle: the next state is computed in a single pass from the
// state registers and lands in the output register on the same edge, so the
// rate is one item per cycle, limited only by the output register being
// drained. The play-time limit may be written at any time and applies at the
// next note end.
module note_tone_sequencer #(
    parameter int unsigned REST_CAP = nts_pkg::REST_CAP_DEFAULT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire nts_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output nts_pkg::t_out                    o_out_data,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [nts_pkg::LIMIT_W-1:0] i_cfg_data
);

    logic          r_out_valid;
    nts_pkg::t_out r_out_data;
    nts_pkg::t_out result;
    logic          step;

    // The output register frees up in the same cycle it is drained.
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign step        = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    nts_core #(
        .REST_CAP (REST_CAP)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (i_in_data),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

FILE: src/nts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nts_checker
// Port-level checks for the note tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module nts_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_in_valid,
    input wire logic          o_in_ready,
    input wire logic          o_out_valid,
    input wire logic          i_out_ready,
    input wire nts_pkg::t_out o_out_data
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_transfer_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted command gave no result");

    a_stop_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.stopped |-> o_out_data.finished
            && !o_out_data.note_ready)
        else $error("stopped without finished");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.note_ready |-> !o_out_data.pin_level
            && !o_out_data.finished)
        else $error("ready while playing or finished");

endmodule

bind note_tone_sequencer nts_checker u_nts_checker (.*);
`default_nettype wire

FILE: bench/tb_note_tone_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_note_tone_sequencer
// Self-checking bench for the buzzer note player.
// ----------------------------------------------------------------------------
// A short directed table walks the player through its states. After that,
// random melodies run under four idling phases, each with its own play-time
// limit. Every command transfer is run through a local model of the player;
// the status it returns, or the expected word of a known table row, is queued.
// Each status transfer from the block is compared against the oldest queued entry.
module tb_note_tone_sequencer;

    localparam logic [1:0] CMD_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 4000000;
    localparam int         PHASE_ITEMS = 225;
    localparam int         SEND_IDLE [4] = '{0, 77, 0, 20};
    localparam int         RECV_STALL[4] = '{0, 0, 77, 20};

    typedef logic [nts_pkg::LIMIT_W-1:0] t_limit;

    typedef enum logic [2:0] {
        P_IDLE, P_READY, P_REST, P_HIGH, P_LOW, P_STOPPED, P_FINISHED
    } t_phase;

    typedef struct {
        nts_pkg::t_in  item;
        bit            known;
        nts_pkg::t_out want;
    } t_row;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    nts_pkg::t_in  in_data   = '0;
    logic          out_ready = 1'b0;
    logic          cfg_valid = 1'b0;
    t_limit        cfg_data  = '0;
    logic          in_ready;
    logic          out_valid;
    nts_pkg::t_out out_data;
    logic          cfg_ready;

    // Local copy of the player state.
    t_phase        ph         = P_IDLE;
    logic [18:0]   rest_cnt   = '0;
    logic [14:0]   half_cnt   = '0;
    logic [15:0]   period_q   = '0;
    logic [23:0]   length_q   = '0;
    logic [24:0]   note_time  = '0;
    logic [26:0]   play_total = '0;
    logic          last_note  = 1'b0;
    logic          pin_q      = 1'b0;
    t_limit        limit_q    = nts_pkg::LIMIT_RESET;

    nts_pkg::t_out pending_status[$];
    int   mismatches     = 0;
    int   sent_items     = 0;
    int   cycles         = 0;
    int   hold_left      = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;

    note_tone_sequencer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off while hold_left counts down.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        nts_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status %b arrived with nothing pending", out_data);
            end else begin
                want = pending_status.pop_front();
                if (out_data.pin_level !== want.pin_level ||
                    out_data.note_ready !== want.note_ready ||
                    out_data.stopped !== want.stopped ||
                    out_data.finished !== want.finished ||
                    out_data.rejected !== want.rejected) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"status mismatch (expected/actual): pin %b/%b ready %b/%b",
                                  " stopped %b/%b finished %b/%b rejected %b/%b"},
                                 want.pin_level, out_data.pin_level,
                                 want.note_ready, out_data.note_ready,
                                 want.stopped, out_data.stopped,
                                 want.finished, out_data.finished,
                                 want.rejected, out_data.rejected);
                end
            end
        end
    end

    function automatic nts_pkg::t_in make_item(logic [1:0] c, logic [23:0] r,
                                               logic [15:0] p, logic [23:0] d, logic f);
        nts_pkg::t_in it;
        it.cmd           = c;
        it.rest_delay    = r;
        it.tone_period   = p;
        it.tone_duration = d;
        it.final_note    = f;
        return it;
    endfunction

    // A load or spare command with every field random.
    function automatic nts_pkg::t_in noise_item();
        return make_item($urandom_range(1) ? nts_pkg::CMD_LOAD : CMD_SPARE, 24'($urandom),
                         16'($urandom), 24'($urandom), 1'($urandom));
    endfunction

    function automatic bit playing();
        return ph == P_REST || ph == P_HIGH || ph == P_LOW;
    endfunction

    function automatic void close_note();
        pin_q      = 1'b0;
        play_total = play_total + 27'(note_time);
        if (play_total > 27'(limit_q))
            ph = P_STOPPED;
        else if (last_note)
            ph = P_FINISHED;
        else
            ph = P_READY;
    endfunction

    // Starts the next square-wave cycle, or ends the note once its time is used up or its period has no half-cycle.
    function automatic void next_cycle();
        if (note_time < 25'(length_q) && period_q[15:1] != 0) begin
            pin_q    = 1'b1;
            half_cnt = period_q[15:1];
            ph       = P_HIGH;
        end else begin
            // A period of one has no half-cycle, so the whole duration counts at once.
            if (note_time < 25'(length_q) && period_q == 16'd1)
                note_time = 25'(length_q);
            close_note();
        end
    endfunction

    function automatic nts_pkg::t_out next_status(nts_pkg::t_in it);
        nts_pkg::t_out r;
        r = '0;
        case (it.cmd)
            nts_pkg::CMD_START: begin
                play_total = '0;
                pin_q      = 1'b0;
                rest_cnt   = '0;
                half_cnt   = '0;
                note_time  = '0;
                ph         = P_READY;
            end
            nts_pkg::CMD_LOAD: begin
                if (ph != P_READY) begin
                    r.rejected = 1'b1;
                end else begin
                    rest_cnt   = (it.rest_delay > 24'(nts_pkg::REST_CAP_DEFAULT)) ?
                                 19'(nts_pkg::REST_CAP_DEFAULT) : it.rest_delay[18:0];
                    play_total = play_total + 27'(rest_cnt);
                    period_q   = it.tone_period;
                    length_q   = it.tone_duration;
                    last_note  = it.final_note;
                    note_time  = '0;
                    pin_q      = 1'b0;
                    if (rest_cnt != 0)
                        ph = P_REST;
                    else
                        next_cycle();
                end
            end
            nts_pkg::CMD_TICK: begin
                case (ph)
                    P_REST: begin
                        rest_cnt = rest_cnt - 1'b1;
                        if (rest_cnt == 0)
                            next_cycle();
                    end
                    P_HIGH: begin
                        half_cnt = half_cnt - 1'b1;
                        if (half_cnt == 0) begin
                            pin_q    = 1'b0;
                            half_cnt = period_q[15:1];
                            ph       = P_LOW;
                        end
                    end
                    P_LOW: begin
                        half_cnt = half_cnt - 1'b1;
                        if (half_cnt == 0) begin
                            note_time = note_time + 25'(period_q);
                            next_cycle();
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.pin_level  = pin_q;
        r.note_ready = (ph == P_READY);
        r.stopped    = (ph == P_STOPPED);
        r.finished   = (ph == P_STOPPED || ph == P_FINISHED);
        return r;
    endfunction

    // Valid stays high after a transfer; callers that pause go through drain_status.
    task automatic send_cmd(input nts_pkg::t_in it, input bit known = 1'b0,
                            input nts_pkg::t_out want = '0);
        nts_pkg::t_out guess;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        guess = next_status(it);
        pending_status.push_back(known ? want : guess);
        sent_items++;
    endtask

    task automatic drain_status();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_status.size() != 0);
    endtask

    task automatic write_limit(input t_limit value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        limit_q = value;
    endtask

    task automatic play_melody();
        nts_pkg::t_in note;
        int  notes;
        int  ticks;
        bit  cut_short;
        send_cmd(make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0));
        notes = $urandom_range(1, 4);
        for (int k = 0; k < notes && ph == P_READY; k++) begin
            note = make_item(nts_pkg::CMD_LOAD,
                             ($urandom_range(3) == 0) ? 24'd0 : 24'($urandom_range(1, 12)),
                             16'($urandom_range(0, 10)), 24'($urandom_range(0, 40)),
                             (k == notes - 1) ? 1'($urandom) : ($urandom_range(7) == 0));
            cut_short = 1'b0;
            case ($urandom_range(19))
                0: begin
                    note.rest_delay = 24'($urandom);
                    cut_short       = 1'b1;
                end
                1: begin
                    note.tone_period   = 16'($urandom);
                    note.tone_duration = 24'($urandom);
                    cut_short          = 1'b1;
                end
                2: begin
                    note.tone_period   = 16'($urandom_range(1));
                    note.tone_duration = 24'($urandom);
                end
                default: ;
            endcase
            send_cmd(note);
            ticks = 0;
            while (playing()) begin
                // Long notes are cut off by a start in the middle of the rest or tone.
                if (cut_short && ticks >= 30) begin
                    send_cmd(make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0));
                end else if ($urandom_range(15) == 0) begin
                    send_cmd(noise_item());
                end else begin
                    send_cmd(make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0));
                    ticks++;
                end
            end
        end
        repeat ($urandom_range(0, 2))
            send_cmd(ph == P_READY ? make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0)
                                   : noise_item());
    endtask

    initial begin
        t_row script[$];
        int   goal;

        // Status bits in the table: pin, ready, stopped, finished, rejected.
        script.push_back('{make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00000)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF,
                                     1'b1),
                           1'b1, nts_pkg::t_out'(5'b00001)});
        script.push_back('{make_item(CMD_SPARE, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1),
                           1'b1, nts_pkg::t_out'(5'b00000)});
        script.push_back('{make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b01000)});
        // A zero period plays no tone and the note ends at once.
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, '0, 24'd100, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b01000)});
        // A period of one takes the whole duration, which is over the default limit.
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, 16'd1, 24'hFFFFFF, 1'b0),
                           1'b1, nts_pkg::t_out'(5'b00110)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00111)});
        script.push_back('{make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00110)});
        script.push_back('{make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b01000)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, 24'd2, 16'd4, 24'd5, 1'b1),
                           1'b1, nts_pkg::t_out'(5'b00000)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00001)});
        repeat (10)
            script.push_back('{make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0), 1'b0,
                               nts_pkg::t_out'(5'b00000)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00011)});
        script.push_back('{make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b01000)});
        script.push_back('{make_item(nts_pkg::CMD_LOAD, '0, '0, '0, 1'b1), 1'b1,
                           nts_pkg::t_out'(5'b00010)});
        script.push_back('{make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0), 1'b1,
                           nts_pkg::t_out'(5'b00010)});

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_cmd(script[i].item, script[i].known, script[i].want);

        // A long capped rest, cut short by a start, with the receiver held off
        // for a while so the block backs up and stalls its input.
        drain_status();
        write_limit({nts_pkg::LIMIT_W{1'b1}});
        send_cmd(make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0));
        send_cmd(make_item(nts_pkg::CMD_LOAD, 24'hFFFFFF, 16'hFFFF, 24'd1, 1'b0));
        for (int t = 0; t < 100; t++) begin
            if (t == 20)
                hold_left <= 400;
            send_cmd(make_item(nts_pkg::CMD_TICK, '0, '0, '0, 1'b0));
        end
        send_cmd(make_item(nts_pkg::CMD_START, '0, '0, '0, 1'b0));
        // Whole-duration notes until the total runs past the largest limit.
        while (ph == P_READY)
            send_cmd(make_item(nts_pkg::CMD_LOAD, '0, 16'd1, 24'hFFFFFF, 1'b0));
        send_cmd(noise_item());

        for (int p = 0; p < 4; p++) begin
            drain_status();
            send_idle_pct  = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            case (p)
                0:       write_limit('0);
                1:       write_limit(t_limit'($urandom_range(30, 120)));
                2:       write_limit(t_limit'($urandom_range(40, 300)));
                default: write_limit(t_limit'($urandom));
            endcase
            goal = sent_items + PHASE_ITEMS;
            while (sent_items < goal)
                play_melody();
        end

        drain_status();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: files.f
src/nts_pkg.sv
src/nts_core.sv
src/note_tone_sequencer.sv
src/nts_checker.sv
bench/tb_note_tone_sequencer.sv
